>>> rtl/tcf_pkg.sv
// Shared constants, register codes and helper functions of the tilt filter.
package tcf_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 8;
    localparam int Z_FRAC           = 20;
    localparam int DATA_W           = 16;
    localparam int ANG_W            = 17;
    localparam int WEIGHT_W         = 17;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DB_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DB_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

    // atan(2^-i) in degrees, Q20
    function automatic logic signed [31:0] atan_q20(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd47185920;
            5'd1:    v = 32'sd27855475;
            5'd2:    v = 32'sd14718068;
            5'd3:    v = 32'sd7471121;
            5'd4:    v = 32'sd3750058;
            5'd5:    v = 32'sd1876857;
            5'd6:    v = 32'sd938658;
            5'd7:    v = 32'sd469357;
            5'd8:    v = 32'sd234682;
            5'd9:    v = 32'sd117342;
            5'd10:   v = 32'sd58671;
            5'd11:   v = 32'sd29335;
            5'd12:   v = 32'sd14668;
            5'd13:   v = 32'sd7334;
            5'd14:   v = 32'sd3667;
            5'd15:   v = 32'sd1833;
            5'd16:   v = 32'sd917;
            5'd17:   v = 32'sd458;
            5'd18:   v = 32'sd229;
            5'd19:   v = 32'sd115;
            5'd20:   v = 32'sd57;
            5'd21:   v = 32'sd29;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp to the 17-bit angle range
    function automatic logic signed [ANG_W-1:0] sat17(input logic signed [39:0] v);
        logic signed [ANG_W-1:0] r;
        if (v < -40'sd65536) begin
            r = -17'sd65536;
        end else if (v > 40'sd65535) begin
            r = 17'sd65535;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/tcf_if.sv
// Request, response and configuration channel interfaces of the tilt filter.
interface tcf_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic signed [tcf_pkg::DATA_W-1:0] accel_x;
    logic signed [tcf_pkg::DATA_W-1:0] accel_y;
    logic signed [tcf_pkg::DATA_W-1:0] accel_z;
    logic signed [tcf_pkg::DATA_W-1:0] gyro_x;
    modport source (output valid, opcode, accel_x, accel_y, accel_z, gyro_x, input ready);
    modport sink   (input valid, opcode, accel_x, accel_y, accel_z, gyro_x, output ready);
endinterface

interface tcf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tcf_pkg::ANG_W-1:0] accel_angle;
    logic signed [tcf_pkg::ANG_W-1:0] gyro_angle;
    logic signed [tcf_pkg::ANG_W-1:0] fused_angle;
    logic                             run_active;
    logic                             tilt_fault;
    modport source (output valid, accel_angle, gyro_angle, fused_angle, run_active,
                    tilt_fault, input ready);
    modport sink   (input valid, accel_angle, gyro_angle, fused_angle, run_active,
                    tilt_fault, output ready);
endinterface

interface tcf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcf_pkg::CFG_IDX_W-1:0]        index;
    logic [tcf_pkg::CFG_DATA_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tilt_complementary_filter_unit.sv
// Top level of the tilt complementary filter: registers, sequencer and blend.
//
//  channel  | direction | handshake    | carries
//  i_req    | in        | valid/ready  | opcode, accel_x/y/z, gyro_x
//  o_rsp    | out       | valid/ready  | accel/gyro/fused angle, run, fault
//  i_cfg    | in        | valid/ready  | register index, write data
//
// A sample runs the bit-serial square root and then the CORDIC steps, with the gyro
// product formed meanwhile, and ends with the blend products. A toggle request goes
// straight to the output state. One request is in flight at a time.
// The result waits in the output register; a stalled output holds the next
// request in its final state. Reset is synchronous and loads the register defaults.
module tilt_complementary_filter_unit #(
    parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcf_in_if.sink     i_req,
    tcf_out_if.source  o_rsp,
    tcf_cfg_if.sink    i_cfg
);
    import tcf_pkg::*;

    localparam int TW = ANGLE_FRAC_BITS + 10;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_BL1  = 3'd3;
    localparam logic [2:0] S_BL2  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;

    logic signed [DATA_W-1:0]   r_db_low, r_db_high, r_offset;
    logic [WEIGHT_W-1:0]        r_weight;
    logic [DATA_W-1:0]          r_limit, r_gain;

    logic signed [ANG_W-1:0]    r_est, r_last_acc, r_last_gyr;
    logic                       r_run;

    logic                       r_tog;
    logic signed [DATA_W-1:0]   r_ax, r_ay, r_az, r_gx;
    logic signed [32:0]         r_gprod;
    logic signed [ANG_W-1:0]    r_acc, r_gyr, r_fused;
    logic signed [35:0]         r_p1, r_p2;

    logic                       r_o_valid;
    logic signed [ANG_W-1:0]    r_o_acc, r_o_gyr, r_o_fused;
    logic                       r_o_run, r_o_fault;

    logic signed [31:0]         sq_x, sq_z;
    logic [31:0]                sum_sq;
    logic                       cor_done;
    logic signed [TW-1:0]       cor_tilt;
    logic [WEIGHT_W-1:0]        w_eff;
    logic [WEIGHT_W:0]          w_comp;
    logic signed [37:0]         blend;
    logic signed [ANG_W:0]      mag;
    logic                       out_free;
    logic                       o_load;

    always_comb begin
        sq_x     = r_ax * r_ax;
        sq_z     = r_az * r_az;
        sum_sq   = $unsigned(sq_x) + $unsigned(sq_z);
        w_eff    = (r_weight > 17'd65536) ? 17'd65536 : r_weight;
        w_comp   = 18'd65536 - {1'b0, w_eff};
        blend    = 38'(r_p1) + 38'(r_p2) + 38'sd32768;
        mag      = r_fused[ANG_W-1] ? -18'(r_fused) : 18'(r_fused);
        out_free = !r_o_valid || o_rsp.ready;
        o_load   = (r_state == S_OUT) && out_free;
    end

    tcf_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQ),
        .i_sum   (sum_sq),
        .i_ay    (r_ay),
        .o_done  (cor_done),
        .o_tilt  (cor_tilt)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_low  <= -16'sd120;
            r_db_high <= 16'sd30;
            r_offset  <= 16'sd768;
            r_weight  <= 17'd11796;
            r_limit   <= 16'd25600;
            r_gain    <= 16'd640;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DB_LOW:  r_db_low  <= i_cfg.data[DATA_W-1:0];
                REG_DB_HIGH: r_db_high <= i_cfg.data[DATA_W-1:0];
                REG_OFFSET:  r_offset  <= i_cfg.data[DATA_W-1:0];
                REG_WEIGHT:  r_weight  <= i_cfg.data;
                REG_LIMIT:   r_limit   <= i_cfg.data[DATA_W-1:0];
                REG_GAIN:    r_gain    <= i_cfg.data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_est      <= '0;
            r_last_acc <= '0;
            r_last_gyr <= '0;
            r_run      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_tog <= (i_req.opcode == OP_TOGGLE);
                        r_ax  <= i_req.accel_x;
                        r_ay  <= i_req.accel_y;
                        r_az  <= i_req.accel_z;
                        // zero the gyro inside the open deadband
                        r_gx  <= (i_req.gyro_x > r_db_low && i_req.gyro_x < r_db_high)
                                 ? '0 : i_req.gyro_x;
                        r_state <= (i_req.opcode == OP_TOGGLE) ? S_OUT : S_SQ;
                    end
                end
                S_SQ: begin
                    r_gprod <= r_gx * $signed({1'b0, r_gain});
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_gyr <= sat17(40'(r_est) + 40'(r_gprod >>> 12));
                    if (cor_done) begin
                        r_acc   <= sat17(40'(cor_tilt) + 40'(r_offset));
                        r_state <= S_BL1;
                    end
                end
                S_BL1: begin
                    r_p1    <= 36'($signed({1'b0, w_eff}) * r_acc);
                    r_p2    <= 36'($signed({1'b0, w_comp}) * r_gyr);
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_fused <= sat17(40'(blend >>> 16));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_tog) begin
                            r_run     <= !r_run;
                            r_o_run   <= !r_run;
                            r_o_fault <= 1'b0;
                            r_o_acc   <= r_last_acc;
                            r_o_gyr   <= r_last_gyr;
                            r_o_fused <= r_est;
                        end else begin
                            r_est      <= r_fused;
                            r_last_acc <= r_acc;
                            r_last_gyr <= r_gyr;
                            r_o_acc    <= r_acc;
                            r_o_gyr    <= r_gyr;
                            r_o_fused  <= r_fused;
                            if (mag > $signed({2'b00, r_limit})) begin
                                r_run     <= 1'b0;
                                r_o_run   <= 1'b0;
                                r_o_fault <= 1'b1;
                            end else begin
                                r_o_run   <= r_run;
                                r_o_fault <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.accel_angle = r_o_acc;
    assign o_rsp.gyro_angle  = r_o_gyr;
    assign o_rsp.fused_angle = r_o_fused;
    assign o_rsp.run_active  = r_o_run;
    assign o_rsp.tilt_fault  = r_o_fault;

endmodule

>>> rtl/tcf_cordic.sv
// Bit-serial square root followed by a CORDIC vectoring pass for the accel tilt.
module tcf_cordic #(
    parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [31:0]                       i_sum,
    input  logic signed [tcf_pkg::DATA_W-1:0] i_ay,
    output logic                              o_done,
    output logic signed [ANGLE_FRAC_BITS+9:0] o_tilt
);
    import tcf_pkg::*;

    localparam int SH = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int TW = ANGLE_FRAC_BITS + 10;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_SQRT = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]         r_state;
    logic [4:0]         r_cnt;
    logic [63:0]        r_v;
    logic [35:0]        r_rem;
    logic [31:0]        r_root;
    logic signed [35:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic               r_ay_zero;
    logic signed [TW-1:0] r_tilt;
    logic               r_done;

    logic [35:0]        rem_sh, trial;
    logic signed [35:0] dx, dy;
    logic signed [31:0] ang, q;

    always_comb begin
        rem_sh = {r_rem[33:0], r_v[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        dx     = r_y >>> r_cnt;
        dy     = r_x >>> r_cnt;
        ang    = atan_q20(r_cnt);
        q      = -r_z + (32'sd1 <<< (SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_v       <= {i_sum, 32'd0};
                        r_rem     <= '0;
                        r_root    <= '0;
                        r_cnt     <= '0;
                        r_ay_zero <= (i_ay == '0);
                        r_y       <= 36'(i_ay) <<< 16;
                        r_state   <= C_SQRT;
                    end
                end
                C_SQRT: begin
                    // one root bit per cycle, two radicand bits shifted in
                    r_v <= {r_v[61:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    if (r_cnt == 5'd31) begin
                        r_cnt   <= '0;
                        r_state <= C_ROT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                C_ROT: begin
                    // first step takes x from the root and starts z at zero
                    if (!r_y[35]) begin
                        r_x <= (r_cnt == '0 ? 36'($signed({1'b0, r_root})) : r_x) + dx;
                        r_y <= r_y - (r_cnt == '0 ? 36'($signed({1'b0, r_root})) : dy);
                        r_z <= (r_cnt == '0 ? 32'sd0 : r_z) + ang;
                    end else begin
                        r_x <= (r_cnt == '0 ? 36'($signed({1'b0, r_root})) : r_x) - dx;
                        r_y <= r_y + (r_cnt == '0 ? 36'($signed({1'b0, r_root})) : dy);
                        r_z <= (r_cnt == '0 ? 32'sd0 : r_z) - ang;
                    end
                    if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                        r_state <= C_FIN;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                C_FIN: begin
                    r_tilt  <= r_ay_zero ? '0 : TW'(q >>> SH);
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_tilt = r_tilt;

endmodule
